/* hdl/icaf_pkg.sv */
// ----------------------------------------------------------------------------
// icaf_pkg : shared constants, types and functions of the attitude filter
// Widths of the division, square-root and CORDIC datapaths, register index
// codes, the arctangent table and the signed 32-bit saturation helper.
// ----------------------------------------------------------------------------
`default_nettype none

package icaf_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 24;
  localparam int CORDIC_N     = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;

  // Restoring division of a 64-bit numerator, one quotient bit per cycle.
  localparam int DIV_STEPS = 64;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int DIVR_W    = 18;
  localparam int QUO_W     = 51;
  localparam int INC_W     = QUO_W + 1;

  // Square root of a 48-bit radicand, two radicand bits per cycle.
  localparam int ROOT_W  = 24;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int SQREM_W = ROOT_W + 3;

  localparam int CRD_W  = 44;
  localparam int ANG_W  = 25;
  localparam int TCNT_W = 5;
  localparam int SAT_W  = 64;
  localparam int WT_W   = 17;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 3'd4;

  localparam logic [1:0] RNG_131  = 2'd0;
  localparam logic [1:0] RNG_65_5 = 2'd1;
  localparam logic [1:0] RNG_32_8 = 2'd2;
  localparam logic [1:0] RNG_16_4 = 2'd3;

  typedef logic signed [INC_W-1:0] inc_t;
  typedef logic signed [ANG_W-1:0] ang_t;

  localparam ang_t NINETY_Q16 = 25'sd5898240;

  localparam logic signed [SAT_W-1:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [SAT_W-1:0] S32_MIN = -64'sd2147483648;

  // Sensitivity in tenths of an LSB per deg/s, times 100 for the millisecond step.
  function automatic logic [DIVR_W-1:0] sens_div(input logic [1:0] rng);
    logic [DIVR_W-1:0] v;
    case (rng)
      RNG_131:  v = 18'd131000;
      RNG_65_5: v = 18'd65500;
      RNG_32_8: v = 18'd32800;
      RNG_16_4: v = 18'd16400;
      default:  v = 18'd131000;
    endcase
    return v;
  endfunction

  // CORDIC arctangent table in degrees, Q16.16.
  function automatic ang_t atan_deg(input logic [TCNT_W-1:0] idx);
    ang_t v;
    case (idx)
      5'd0:    v = 25'sd2949120;
      5'd1:    v = 25'sd1740967;
      5'd2:    v = 25'sd919879;
      5'd3:    v = 25'sd466945;
      5'd4:    v = 25'sd234379;
      5'd5:    v = 25'sd117304;
      5'd6:    v = 25'sd58666;
      5'd7:    v = 25'sd29335;
      5'd8:    v = 25'sd14668;
      5'd9:    v = 25'sd7334;
      5'd10:   v = 25'sd3667;
      5'd11:   v = 25'sd1833;
      5'd12:   v = 25'sd917;
      5'd13:   v = 25'sd458;
      5'd14:   v = 25'sd229;
      5'd15:   v = 25'sd115;
      5'd16:   v = 25'sd57;
      5'd17:   v = 25'sd29;
      5'd18:   v = 25'sd14;
      5'd19:   v = 25'sd7;
      5'd20:   v = 25'sd4;
      5'd21:   v = 25'sd2;
      5'd22:   v = 25'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (v < S32_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hdl/icaf_gyro_lane.sv */
// ----------------------------------------------------------------------------
// icaf_gyro_lane : angle increment of one gyro axis
// Removes the bias, multiplies by the elapsed time and divides by the
// sensitivity with a bit-serial restoring divider, rounding to nearest.
// ----------------------------------------------------------------------------
`default_nettype none

module icaf_gyro_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [15:0]  rate_i,
  input  logic signed [15:0]  bias_i,
  input  logic [31:0]         delta_i,
  input  logic [1:0]          range_i,
  output logic                done_o,
  output icaf_pkg::inc_t      inc_o
);
  import icaf_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_DIV  = 2'd2;
  localparam logic [1:0] PH_RND  = 2'd3;

  logic [1:0]           phase_q, phase_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 done_q, done_d;

  logic                 neg_q;
  logic [15:0]          mag_q;
  logic [31:0]          delta_q;
  logic [DIVR_W-1:0]    divr_q;
  logic [63:0]          num_q;
  logic [DIVR_W-1:0]    rem_q;
  logic [QUO_W-1:0]     quo_q;
  inc_t                 inc_q;

  logic signed [16:0]   diff;
  logic signed [16:0]   diff_neg;
  logic [47:0]          prod;
  logic [DIVR_W:0]      rem_shift;
  logic [DIVR_W:0]      rem_sub;
  logic                 rem_ge;
  logic                 rnd_up;
  logic [QUO_W-1:0]     quo_rnd;
  inc_t                 quo_s;

  assign diff      = $signed({rate_i[15], rate_i}) - $signed({bias_i[15], bias_i});
  assign diff_neg  = -diff;
  assign prod      = mag_q * delta_q;
  assign rem_shift = {rem_q, num_q[63]};
  assign rem_ge    = (rem_shift >= {1'b0, divr_q});
  assign rem_sub   = rem_shift - {1'b0, divr_q};
  assign rnd_up    = ({rem_q, 1'b0} >= {1'b0, divr_q});
  assign quo_rnd   = quo_q + QUO_W'(rnd_up);
  assign quo_s     = $signed({1'b0, quo_rnd});

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    done_d  = done_q;
    case (phase_q)
      PH_IDLE: begin
        if (start_i) begin
          phase_d = PH_MUL;
          done_d  = 1'b0;
        end
      end
      PH_MUL: begin
        phase_d = PH_DIV;
        cnt_d   = '0;
      end
      PH_DIV: begin
        cnt_d = cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          phase_d = PH_RND;
        end
      end
      PH_RND: begin
        phase_d = PH_IDLE;
        done_d  = 1'b1;
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q   <= diff[16];
      mag_q   <= diff[16] ? diff_neg[15:0] : diff[15:0];
      delta_q <= delta_i;
      divr_q  <= sens_div(range_i);
    end
    case (phase_q)
      PH_MUL: begin
        num_q <= {prod, 16'h0000};
        rem_q <= '0;
        quo_q <= '0;
      end
      PH_DIV: begin
        num_q <= {num_q[62:0], 1'b0};
        rem_q <= rem_ge ? rem_sub[DIVR_W-1:0] : rem_shift[DIVR_W-1:0];
        quo_q <= {quo_q[QUO_W-2:0], rem_ge};
      end
      PH_RND: begin
        inc_q <= neg_q ? -quo_s : quo_s;
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign inc_o  = inc_q;

endmodule

`default_nettype wire

/* hdl/icaf_tilt_lane.sv */
// ----------------------------------------------------------------------------
// icaf_tilt_lane : accelerometer tilt angle of one axis
// Forms a^2 + b^2, takes its square root digit by digit and runs a CORDIC
// in vectoring mode to give atan(num / root) in degrees, Q16.16.
// ----------------------------------------------------------------------------
`default_nettype none

module icaf_tilt_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [16:0]  num_i,
  input  logic signed [15:0]  a_i,
  input  logic signed [15:0]  b_i,
  output logic                done_o,
  output icaf_pkg::ang_t      tilt_o
);
  import icaf_pkg::*;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_SQ   = 3'd1;
  localparam logic [2:0] PH_SUM  = 3'd2;
  localparam logic [2:0] PH_ROOT = 3'd3;
  localparam logic [2:0] PH_PREP = 3'd4;
  localparam logic [2:0] PH_CRD  = 3'd5;

  logic [2:0]              phase_q, phase_d;
  logic [TCNT_W-1:0]       cnt_q, cnt_d;
  logic                    done_q, done_d;

  logic signed [16:0]      num_q;
  logic signed [15:0]      a_q, b_q;
  logic [31:0]             sqa_q, sqb_q;
  logic [RAD_W-1:0]        rad_q;
  logic [ROOT_W-1:0]       root_q;
  logic [SQREM_W-1:0]      srem_q;
  logic signed [CRD_W-1:0] x_q, y_q;
  ang_t                    z_q;

  logic signed [31:0]      sqa_w, sqb_w;
  logic [31:0]             sum_w;
  logic                    sum_zero;
  logic [SQREM_W-1:0]      rem2, trial;
  logic                    root_ge;
  logic signed [CRD_W-1:0] dx, dy;
  ang_t                    step_ang;

  assign sqa_w    = a_q * a_q;
  assign sqb_w    = b_q * b_q;
  assign sum_w    = sqa_q + sqb_q;
  assign sum_zero = (sum_w == '0);
  assign rem2     = {srem_q[SQREM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial    = {1'b0, root_q, 2'b01};
  assign root_ge  = (rem2 >= trial);
  assign dx       = x_q >>> cnt_q;
  assign dy       = y_q >>> cnt_q;
  assign step_ang = atan_deg(cnt_q);

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    done_d  = done_q;
    case (phase_q)
      PH_IDLE: begin
        if (start_i) begin
          phase_d = PH_SQ;
          done_d  = 1'b0;
        end
      end
      PH_SQ: phase_d = PH_SUM;
      PH_SUM: begin
        cnt_d = '0;
        if (sum_zero) begin
          phase_d = PH_IDLE;
          done_d  = 1'b1;
        end else begin
          phase_d = PH_ROOT;
        end
      end
      PH_ROOT: begin
        cnt_d = cnt_q + TCNT_W'(1);
        if (cnt_q == TCNT_W'(ROOT_W - 1)) begin
          phase_d = PH_PREP;
        end
      end
      PH_PREP: begin
        phase_d = PH_CRD;
        cnt_d   = '0;
      end
      PH_CRD: begin
        cnt_d = cnt_q + TCNT_W'(1);
        if (cnt_q == TCNT_W'(CORDIC_N - 1)) begin
          phase_d = PH_IDLE;
          done_d  = 1'b1;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      a_q   <= a_i;
      b_q   <= b_i;
    end
    case (phase_q)
      PH_SQ: begin
        sqa_q <= sqa_w;
        sqb_q <= sqb_w;
      end
      PH_SUM: begin
        // A zero denominator gives a right angle signed by the numerator, or zero for a zero numerator.
        if (num_q > 17'sd0) begin
          z_q <= NINETY_Q16;
        end else if (num_q < 17'sd0) begin
          z_q <= -NINETY_Q16;
        end else begin
          z_q <= '0;
        end
        rad_q  <= {sum_w, 16'h0000};
        root_q <= '0;
        srem_q <= '0;
      end
      PH_ROOT: begin
        rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
        srem_q <= root_ge ? (rem2 - trial) : rem2;
        root_q <= {root_q[ROOT_W-2:0], root_ge};
      end
      PH_PREP: begin
        x_q <= $signed({{(CRD_W - ROOT_W - 16){1'b0}}, root_q, 16'h0000});
        y_q <= $signed({{(CRD_W - 17 - 24){num_q[16]}}, num_q, 24'h000000});
        z_q <= '0;
      end
      PH_CRD: begin
        if (!y_q[CRD_W-1]) begin
          x_q <= x_q + dy;
          y_q <= y_q - dx;
          z_q <= z_q + step_ang;
        end else begin
          x_q <= x_q - dy;
          y_q <= y_q + dx;
          z_q <= z_q - step_ang;
        end
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign tilt_o = z_q;

endmodule

`default_nettype wire

/* hdl/icaf_merge.sv */
// ----------------------------------------------------------------------------
// icaf_merge : blend, saturation and filter state
// Combines the gyro increments and tilt angles into the filtered and drift
// angles, holds them as state and presents them as the output beat.
// ----------------------------------------------------------------------------
`default_nettype none

module icaf_merge (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  icaf_pkg::inc_t            inc_x_i,
  input  icaf_pkg::inc_t            inc_y_i,
  input  icaf_pkg::inc_t            inc_z_i,
  input  icaf_pkg::ang_t            tilt_x_i,
  input  icaf_pkg::ang_t            tilt_y_i,
  input  logic signed [15:0]        temp_raw_i,
  input  logic [icaf_pkg::WT_W-1:0] weight_i,
  input  logic                      out_stall_i,
  output logic                      done_o,
  output logic                      out_valid_o,
  output logic signed [31:0]        angle_x_o,
  output logic signed [31:0]        angle_y_o,
  output logic signed [31:0]        angle_z_o,
  output logic signed [31:0]        drift_x_o,
  output logic signed [31:0]        drift_y_o,
  output logic signed [31:0]        drift_z_o,
  output logic signed [16:0]        temp_out_o
);
  import icaf_pkg::*;

  localparam int G_W   = INC_W + 1;
  localparam int HI_W  = G_W - 16;
  localparam int PH_W  = HI_W + WT_W + 1;
  localparam int PL_W  = WT_W + 16;
  localparam int PB_W  = WT_W + 1 + ANG_W;
  localparam int IN_W  = PB_W + 1;
  localparam int RES_W = PH_W + 1;
  localparam int TP_W  = 51;
  localparam int T_SH  = 34;

  localparam logic [WT_W-1:0] ONE_Q16     = 17'd65536;
  localparam logic [25:0]     TEMP_RECIP  = 26'd50529028;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_SUM  = 2'd1;
  localparam logic [1:0] PH_MUL  = 2'd2;
  localparam logic [1:0] PH_FIN  = 2'd3;

  logic [1:0]              phase_q, phase_d;
  logic                    out_valid_q, out_valid_d;
  logic signed [31:0]      filt_x_q, filt_y_q, filt_z_q;
  logic signed [31:0]      integ_x_q, integ_y_q, integ_z_q;

  logic signed [G_W-1:0]   gx_q, gy_q;
  logic [TP_W-1:0]         tprod_q;
  logic signed [PH_W-1:0]  pah_x_q, pah_y_q;
  logic [PL_W-1:0]         pal_x_q, pal_y_q;
  logic signed [PB_W-1:0]  pb_x_q, pb_y_q;
  logic signed [16:0]      temp_q;

  logic [WT_W-1:0]         alpha, beta;
  logic signed [26:0]      tn_s;
  logic [TP_W-1:0]         tprod_w;
  logic signed [PH_W-1:0]  pah_x_w, pah_y_w;
  logic [PL_W-1:0]         pal_x_w, pal_y_w;
  logic signed [PB_W-1:0]  pb_x_w, pb_y_w;
  logic signed [IN_W-1:0]  inner_x, inner_y;
  logic signed [RES_W-1:0] res_x, res_y;
  logic signed [17:0]      temp_w;
  logic                    out_free;

  assign alpha   = (weight_i > ONE_Q16) ? ONE_Q16 : weight_i;
  assign beta    = ONE_Q16 - alpha;
  assign tn_s    = (27'(temp_raw_i) + 27'sd12412) * 27'sd256 + 27'sd6800170;
  assign tprod_w = tn_s[24:0] * TEMP_RECIP;

  assign pah_x_w = $signed({1'b0, alpha}) * $signed(gx_q[G_W-1:16]);
  assign pah_y_w = $signed({1'b0, alpha}) * $signed(gy_q[G_W-1:16]);
  assign pal_x_w = alpha * gx_q[15:0];
  assign pal_y_w = alpha * gy_q[15:0];
  assign pb_x_w  = $signed({1'b0, beta}) * tilt_x_i;
  assign pb_y_w  = $signed({1'b0, beta}) * tilt_y_i;

  assign inner_x = $signed({{(IN_W - PL_W){1'b0}}, pal_x_q}) + IN_W'(pb_x_q)
                   + IN_W'(32768);
  assign inner_y = $signed({{(IN_W - PL_W){1'b0}}, pal_y_q}) + IN_W'(pb_y_q)
                   + IN_W'(32768);
  assign res_x   = RES_W'(pah_x_q) + RES_W'(inner_x >>> 16);
  assign res_y   = RES_W'(pah_y_q) + RES_W'(inner_y >>> 16);

  assign temp_w   = $signed({1'b0, tprod_q[TP_W-1:T_SH]}) - 18'sd20000;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    phase_d     = phase_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (phase_q)
      PH_IDLE: begin
        if (start_i) begin
          phase_d = PH_SUM;
        end
      end
      PH_SUM: phase_d = PH_MUL;
      PH_MUL: phase_d = PH_FIN;
      PH_FIN: begin
        if (out_free) begin
          phase_d     = PH_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      out_valid_q <= 1'b0;
      filt_x_q    <= '0;
      filt_y_q    <= '0;
      filt_z_q    <= '0;
      integ_x_q   <= '0;
      integ_y_q   <= '0;
      integ_z_q   <= '0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
      // The state doubles as the output beat; it only moves once the last
      // beat has been taken.
      if (phase_q == PH_FIN && out_free) begin
        filt_x_q  <= sat32(SAT_W'(res_x));
        filt_y_q  <= sat32(SAT_W'(res_y));
        filt_z_q  <= sat32(SAT_W'(filt_z_q) + SAT_W'(inc_z_i));
        integ_x_q <= sat32(SAT_W'(integ_x_q) + SAT_W'(inc_x_i));
        integ_y_q <= sat32(SAT_W'(integ_y_q) + SAT_W'(inc_y_i));
        integ_z_q <= sat32(SAT_W'(integ_z_q) + SAT_W'(inc_z_i));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (phase_q)
      PH_SUM: begin
        gx_q    <= G_W'(filt_x_q) + G_W'(inc_x_i);
        gy_q    <= G_W'(filt_y_q) + G_W'(inc_y_i);
        tprod_q <= tprod_w;
      end
      PH_MUL: begin
        pah_x_q <= pah_x_w;
        pah_y_q <= pah_y_w;
        pal_x_q <= pal_x_w;
        pal_y_q <= pal_y_w;
        pb_x_q  <= pb_x_w;
        pb_y_q  <= pb_y_w;
      end
      PH_FIN: begin
        if (out_free) begin
          temp_q <= temp_w[16:0];
        end
      end
      default: ;
    endcase
  end

  assign done_o      = (phase_q == PH_FIN) && out_free;
  assign out_valid_o = out_valid_q;
  assign angle_x_o   = filt_x_q;
  assign angle_y_o   = filt_y_q;
  assign angle_z_o   = filt_z_q;
  assign drift_x_o   = integ_x_q;
  assign drift_y_o   = integ_y_q;
  assign drift_z_o   = integ_z_q;
  assign temp_out_o  = temp_q;

endmodule

`default_nettype wire

/* hdl/imu_complementary_attitude_filter_top.sv */
// ----------------------------------------------------------------------------
// imu_complementary_attitude_filter_top : six-axis complementary attitude filter
// Top level with the configuration registers, the sample sequencer, three gyro
// lanes, two tilt lanes and the merging stage.
// ----------------------------------------------------------------------------
// One input beat carries a raw accelerometer, gyro and temperature sample with
// a millisecond timestamp, and produces exactly one output beat of filtered,
// drift and temperature values. The block works on one sample at a time: the
// next sample may be accepted in the same cycle as the output beat of the last
// one first appears, even if that beat is still waiting to be taken. The time
// to the output beat is set by the 64-step restoring divider in each gyro
// lane, which turns the scaled rate into an angle increment one quotient bit
// per cycle; the tilt lanes (square root and CORDIC) finish earlier in
// parallel, and the merging stage follows with its sum, multiply and final
// steps. Configuration writes are always taken and must only be issued while
// no sample is in progress.
`default_nettype none

module imu_complementary_attitude_filter_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [15:0]             accel_x_i,
  input  logic signed [15:0]             accel_y_i,
  input  logic signed [15:0]             accel_z_i,
  input  logic signed [15:0]             rate_x_i,
  input  logic signed [15:0]             rate_y_i,
  input  logic signed [15:0]             rate_z_i,
  input  logic signed [15:0]             temp_raw_i,
  input  logic [31:0]                    time_ms_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [31:0]             angle_x_o,
  output logic signed [31:0]             angle_y_o,
  output logic signed [31:0]             angle_z_o,
  output logic signed [31:0]             drift_x_o,
  output logic signed [31:0]             drift_y_o,
  output logic signed [31:0]             drift_z_o,
  output logic signed [16:0]             temp_out_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [icaf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [icaf_pkg::WT_W-1:0]      cfg_data_i
);
  import icaf_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LANES = 2'd1;
  localparam logic [1:0] ST_MERGE = 2'd2;

  logic [1:0]         state_q, state_d;
  logic signed [15:0] bias_x_q, bias_y_q, bias_z_q;
  logic [1:0]         range_q;
  logic [WT_W-1:0]    weight_q;
  logic [31:0]        prev_time_q;
  logic signed [15:0] temp_raw_q;

  logic               accept;
  logic [31:0]        delta;
  logic [2:0]         gyro_done;
  logic [1:0]         tilt_done;
  logic               lanes_done;
  logic               merge_start;
  logic               merge_done;
  inc_t               inc_x, inc_y, inc_z;
  ang_t               tilt_x, tilt_y;
  logic signed [16:0] num_x, num_y;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // The elapsed time wraps modulo 2^32, so a timestamp that steps backwards
  // still yields a plain unsigned difference.
  assign delta = time_ms_i - prev_time_q;

  // Tilt about x uses accel y over the x/z magnitude; tilt about y uses the
  // negated accel x over the y/z magnitude.
  assign num_x = {accel_y_i[15], accel_y_i};
  assign num_y = -$signed({accel_x_i[15], accel_x_i});

  assign lanes_done  = (&gyro_done) && (&tilt_done);
  assign merge_start = (state_q == ST_LANES) && lanes_done;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_LANES;
        end
      end
      ST_LANES: begin
        if (lanes_done) begin
          state_d = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (merge_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      prev_time_q <= '0;
      bias_x_q    <= '0;
      bias_y_q    <= '0;
      bias_z_q    <= '0;
      range_q     <= RNG_131;
      weight_q    <= 17'd62915;
    end else begin
      state_q <= state_d;
      if (accept) begin
        prev_time_q <= time_ms_i;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_BIAS_X: bias_x_q <= cfg_data_i[15:0];
          CFG_BIAS_Y: bias_y_q <= cfg_data_i[15:0];
          CFG_BIAS_Z: bias_z_q <= cfg_data_i[15:0];
          CFG_RANGE:  range_q  <= cfg_data_i[1:0];
          CFG_WEIGHT: weight_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      temp_raw_q <= temp_raw_i;
    end
  end

  icaf_gyro_lane u_gyro_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .rate_i  (rate_x_i),
    .bias_i  (bias_x_q),
    .delta_i (delta),
    .range_i (range_q),
    .done_o  (gyro_done[0]),
    .inc_o   (inc_x)
  );

  icaf_gyro_lane u_gyro_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .rate_i  (rate_y_i),
    .bias_i  (bias_y_q),
    .delta_i (delta),
    .range_i (range_q),
    .done_o  (gyro_done[1]),
    .inc_o   (inc_y)
  );

  icaf_gyro_lane u_gyro_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .rate_i  (rate_z_i),
    .bias_i  (bias_z_q),
    .delta_i (delta),
    .range_i (range_q),
    .done_o  (gyro_done[2]),
    .inc_o   (inc_z)
  );

  icaf_tilt_lane u_tilt_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .num_i   (num_x),
    .a_i     (accel_x_i),
    .b_i     (accel_z_i),
    .done_o  (tilt_done[0]),
    .tilt_o  (tilt_x)
  );

  icaf_tilt_lane u_tilt_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .num_i   (num_y),
    .a_i     (accel_y_i),
    .b_i     (accel_z_i),
    .done_o  (tilt_done[1]),
    .tilt_o  (tilt_y)
  );

  icaf_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (merge_start),
    .inc_x_i     (inc_x),
    .inc_y_i     (inc_y),
    .inc_z_i     (inc_z),
    .tilt_x_i    (tilt_x),
    .tilt_y_i    (tilt_y),
    .temp_raw_i  (temp_raw_q),
    .weight_i    (weight_q),
    .out_stall_i (out_stall_i),
    .done_o      (merge_done),
    .out_valid_o (out_valid_o),
    .angle_x_o   (angle_x_o),
    .angle_y_o   (angle_y_o),
    .angle_z_o   (angle_z_o),
    .drift_x_o   (drift_x_o),
    .drift_y_o   (drift_y_o),
    .drift_z_o   (drift_z_o),
    .temp_out_o  (temp_out_o)
  );

endmodule

`default_nettype wire

/* hdl/icaf_checker.sv */
// ----------------------------------------------------------------------------
// icaf_checker : port-level checks of the attitude filter
// Watches the top level's ports and is attached to it by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module icaf_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic signed [31:0]             angle_x_o,
  input logic signed [16:0]             temp_out_o,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o
);

  // A stalled output beat is held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(angle_x_o))
    else $error("output beat dropped or changed while stalled");

  // One sample at a time: an accepted beat makes the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted while a sample was still in progress");

  // A new output beat only appears at the end of a sample in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("output beat without a sample in progress");

  // The temperature stays within the range its input can produce.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (temp_out_o >= -17'sd15328) && (temp_out_o <= 17'sd34021))
    else $error("temperature out of range");

  // Register writes are never held off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("register write not taken");

endmodule

bind imu_complementary_attitude_filter_top icaf_checker u_icaf_checker (.*);

`default_nettype wire
